FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks an implication in the same cycle, clocked on clk, held off during reset
`define NSS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// checks an implication in the next cycle
`define NSS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hw/rtl/nss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nss_pkg;

	localparam int MAX_STEPS_DEF = 16;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 16;
	localparam int IN_DW  = 40;
	localparam int OUT_DW = 16;
	localparam int LFSR_W = 16;
	localparam int MOD_W  = 6;

	typedef enum logic [CFG_AW-1:0] {
		REG_SEQ_LENGTH = 3'd0,
		REG_LOOP_POINT = 3'd1,
		REG_OCTAVE     = 3'd2,
		REG_NOTES_OCT  = 3'd3,
		REG_ROW_SHIFT  = 3'd4,
		REG_ENABLED    = 3'd5,
		REG_STEP_TICKS = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REQ_PULSE = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_WRITE = 2'd2
	} req_t;

	localparam logic [4:0]  SEQ_LENGTH_RST = 5'd8;
	localparam logic [3:0]  LOOP_POINT_RST = 4'd0;
	localparam logic [2:0]  OCTAVE_RST     = 3'd3;
	localparam logic [4:0]  NOTES_OCT_RST  = 5'd12;
	localparam logic [4:0]  ROW_SHIFT_RST  = 5'd0;
	localparam logic        ENABLED_RST    = 1'b1;
	localparam logic [15:0] STEP_TICKS_RST = 16'd96;
	localparam logic [15:0] LFSR_SEED      = 16'hACE1;
	localparam logic [8:0]  GATE_FULL      = 9'd256;
	localparam logic [6:0]  VEL_MAX        = 7'd127;
	localparam logic [7:0]  PITCH_MAX      = 8'd255;

	typedef struct packed {
		logic [7:0] pitch;
		logic [6:0] vel;
	} note_ev_t;

	typedef struct packed {
		logic [4:0] tone;
		logic [6:0] vel;
		logic [8:0] gate;
	} step_ent_t;

	localparam step_ent_t STEP_RST = '{tone: 5'd0, vel: VEL_MAX, gate: GATE_FULL};

	// fibonacci lfsr, taps 16 14 13 11
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] l);
		logic fb;
		fb = l[0] ^ l[2] ^ l[3] ^ l[5];
		return {fb, l[LFSR_W-1:1]};
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/note_step_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  s_tdata step fields, s_tuser request kind
// m_*      out        m_tvalid/m_tready  m_tdata note event, m_tlast last of item
// cfg_*    in         cfg_we             cfg_addr register index, cfg_wdata value
//
// a write item is done in idle, a tick goes through the tick state, a pulse through
// read, calc and finish, after the mod state for a random jump (one remainder bit
// per cycle), then each event goes out on m_* as m_tready takes it; the step memory
// is read once per pulse into a register, then a multiply stage and a finish stage
// reset clears the step table through per-entry valid bits at once, no clearing pass
// s_tready is high whenever the sequencer is idle, even with an event still in m_*

module note_step_sequencer #(
	parameter int MAX_STEPS = nss_pkg::MAX_STEPS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [nss_pkg::CFG_AW-1:0]  cfg_addr,
	input  wire logic [nss_pkg::CFG_DW-1:0]  cfg_wdata,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// backward, jump_zero, jump_random, pulse_gain, step_index, step_tone,
	// step_velocity, step_gate, zero fill
	input  wire logic [nss_pkg::IN_DW-1:0]   s_tdata,
	// req_type
	input  wire logic [1:0]                  s_tuser,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// note_pitch, note_velocity, zero fill
	output logic [nss_pkg::OUT_DW-1:0]       m_tdata,
	output logic                             m_tlast
);

	localparam int PW = (MAX_STEPS > 2) ? $clog2(MAX_STEPS) : 1;
	localparam int IW = (PW > 4) ? PW : 4;
	localparam int CW = ((PW > 5) ? PW : 5) + 2;
	localparam int DW = $bits(nss_pkg::step_ent_t);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MOD  = 7'b0000010,
		ST_READ = 7'b0000100,
		ST_CALC = 7'b0001000,
		ST_FIN  = 7'b0010000,
		ST_TICK = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	// input fields
	nss_pkg::req_t in_req;
	logic          in_bwd;
	logic          in_jz;
	logic          in_jr;
	logic [7:0]    in_gain;
	logic [3:0]    in_idx;
	logic [4:0]    in_tone;
	logic [6:0]    in_vel;
	logic [8:0]    in_gate;

	assign in_req  = nss_pkg::req_t'(s_tuser);
	assign in_bwd  = s_tdata[0];
	assign in_jz   = s_tdata[1];
	assign in_jr   = s_tdata[2];
	assign in_gain = s_tdata[10:3];
	assign in_idx  = s_tdata[14:11];
	assign in_tone = s_tdata[19:15];
	assign in_vel  = s_tdata[26:20];
	assign in_gate = s_tdata[35:27];

	// configuration registers
	logic [4:0]  seq_length_q;
	logic [3:0]  loop_point_q;
	logic [2:0]  octave_q;
	logic [4:0]  notes_q;
	logic [4:0]  row_shift_q;
	logic        enabled_q;
	logic [15:0] step_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_length_q <= nss_pkg::SEQ_LENGTH_RST;
			loop_point_q <= nss_pkg::LOOP_POINT_RST;
			octave_q     <= nss_pkg::OCTAVE_RST;
			notes_q      <= nss_pkg::NOTES_OCT_RST;
			row_shift_q  <= nss_pkg::ROW_SHIFT_RST;
			enabled_q    <= nss_pkg::ENABLED_RST;
			step_ticks_q <= nss_pkg::STEP_TICKS_RST;
		end else if (cfg_we) begin
			case (nss_pkg::cfg_reg_t'(cfg_addr))
				nss_pkg::REG_SEQ_LENGTH: seq_length_q <= cfg_wdata[4:0];
				nss_pkg::REG_LOOP_POINT: loop_point_q <= cfg_wdata[3:0];
				nss_pkg::REG_OCTAVE:     octave_q     <= cfg_wdata[2:0];
				nss_pkg::REG_NOTES_OCT:  notes_q      <= cfg_wdata[4:0];
				nss_pkg::REG_ROW_SHIFT:  row_shift_q  <= cfg_wdata[4:0];
				nss_pkg::REG_ENABLED:    enabled_q    <= cfg_wdata[0];
				nss_pkg::REG_STEP_TICKS: step_ticks_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// control and play state
	state_t                  state_q;
	logic signed [CW-1:0]    pos_q;
	logic [7:0]              gain_q;
	logic [nss_pkg::LFSR_W-1:0] lfsr_q;
	logic [nss_pkg::LFSR_W-1:0] div_q;
	logic [nss_pkg::MOD_W-1:0]  rem_q;
	logic [$clog2(nss_pkg::LFSR_W)-1:0] cnt_q;
	logic [7:0]              snd_pitch_q;
	logic                    snd_vld_q;
	logic                    off_sent_q;
	logic [8:0]              snd_gate_q;
	logic [31:0]             gate_end_q;
	logic [31:0]             time_q;
	nss_pkg::note_ev_t       ev_q [2];
	logic                    ev_idx_q;
	logic                    ev_last_q;
	nss_pkg::note_ev_t       m_data_q;
	logic                    m_last_q;
	logic                    m_vld_q;

	// step memory with per-entry valid bits
	logic [DW-1:0]           mem [MAX_STEPS];
	logic [MAX_STEPS-1:0]    vld_q;
	logic [DW-1:0]           rd_q;
	logic                    rd_vld_q;
	logic [IW-1:0]           wr_idx;
	logic [PW-1:0]           wr_addr;
	logic                    wr_en;
	logic [PW-1:0]           rd_addr;
	nss_pkg::step_ent_t      wr_ent;

	logic acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign wr_idx   = IW'(in_idx);
	assign wr_addr  = wr_idx[PW-1:0];
	assign wr_en    = acc && (in_req == nss_pkg::REQ_WRITE) && (int'(wr_idx) < MAX_STEPS);
	assign rd_addr  = pos_q[PW-1:0];
	assign wr_ent   = '{tone: in_tone, vel: in_vel, gate: in_gate};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_ent;
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (state_q == ST_READ) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// loop bounds and position move
	logic signed [CW-1:0] sl_c, len_c, lp_c, loop_c, span_c, p1_c, p2_c, p3_c;

	always_comb begin
		sl_c   = CW'(seq_length_q);
		lp_c   = CW'(loop_point_q);
		if (sl_c == CW'(0)) begin
			len_c = CW'(1);
		end else if (sl_c > CW'(MAX_STEPS)) begin
			len_c = CW'(MAX_STEPS);
		end else begin
			len_c = sl_c;
		end
		loop_c = (lp_c > len_c - CW'(1)) ? len_c - CW'(1) : lp_c;
		span_c = len_c - loop_c;
		p1_c   = in_bwd ? pos_q - CW'(1) : pos_q + CW'(1);
		if (!in_bwd && p1_c >= len_c) begin
			p2_c = p1_c - span_c;
		end else if (in_bwd && p1_c < loop_c) begin
			p2_c = p1_c + span_c;
		end else begin
			p2_c = p1_c;
		end
		if (p2_c[CW-1] || p2_c >= len_c) begin
			p3_c = in_bwd ? len_c - CW'(1) : loop_c;
		end else begin
			p3_c = p2_c;
		end
	end

	// one remainder bit per cycle
	logic [nss_pkg::MOD_W-1:0] rem_sh, rem_n, len_m;
	logic [nss_pkg::LFSR_W-1:0] lfsr_n;

	assign len_m  = len_c[nss_pkg::MOD_W-1:0];
	assign rem_sh = {rem_q[nss_pkg::MOD_W-2:0], div_q[nss_pkg::LFSR_W-1]};
	assign rem_n  = (rem_sh >= len_m) ? rem_sh - len_m : rem_sh;
	assign lfsr_n = nss_pkg::lfsr_next(lfsr_q);

	// step entry evaluation, first stage
	nss_pkg::step_ent_t ent;
	logic [8:0]  pitch_w;
	logic [14:0] vg_w;
	logic [8:0]  g_w;
	logic [7:0]  pitch_s1;
	logic [6:0]  ov_s1;
	logic [8:0]  g_s1;
	logic [24:0] prod_s1;
	logic        silent_s1;

	always_comb begin
		ent     = rd_vld_q ? nss_pkg::step_ent_t'(rd_q) : nss_pkg::STEP_RST;
		pitch_w = 9'(ent.tone) + 9'(row_shift_q) + 9'(octave_q) * 9'(notes_q);
		vg_w    = 15'(ent.vel) * 15'(gain_q);
		if (ent.gate == 9'd0) begin
			g_w = 9'd1;
		end else if (ent.gate > nss_pkg::GATE_FULL) begin
			g_w = nss_pkg::GATE_FULL;
		end else begin
			g_w = ent.gate;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			silent_s1 <= (ent.vel <= 7'd1);
			pitch_s1  <= (pitch_w > 9'(nss_pkg::PITCH_MAX)) ? nss_pkg::PITCH_MAX : pitch_w[7:0];
			ov_s1     <= (vg_w[14:7] > 8'(nss_pkg::VEL_MAX)) ? nss_pkg::VEL_MAX : vg_w[13:7];
			g_s1      <= g_w;
			prod_s1   <= 25'(step_ticks_q) * 25'(g_w);
		end
	end

	// event decisions
	logic        off_v;
	logic        retrig;
	logic        tick_fire;
	logic [31:0] diff_w;

	assign off_v     = snd_vld_q && !off_sent_q;
	assign retrig    = off_v && (snd_pitch_q == pitch_s1);
	assign diff_w    = time_q - gate_end_q;
	assign tick_fire = (snd_gate_q < nss_pkg::GATE_FULL) && off_v &&
		(diff_w != 32'd0) && !diff_w[31];

	logic ld_out;
	assign ld_out = (state_q == ST_EMIT) && (!m_vld_q || m_tready);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			m_data_q <= ev_q[ev_idx_q];
			m_last_q <= (ev_idx_q == ev_last_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= -CW'(1);
			gain_q      <= '0;
			lfsr_q      <= nss_pkg::LFSR_SEED;
			div_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			snd_pitch_q <= '0;
			snd_vld_q   <= 1'b0;
			off_sent_q  <= 1'b0;
			snd_gate_q  <= nss_pkg::GATE_FULL;
			gate_end_q  <= '0;
			time_q      <= '0;
			ev_q[0]     <= '0;
			ev_q[1]     <= '0;
			ev_idx_q    <= 1'b0;
			ev_last_q   <= 1'b0;
			m_vld_q     <= 1'b0;
		end else begin
			if (ld_out) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (in_req)
							nss_pkg::REQ_PULSE: begin
								if (enabled_q) begin
									gain_q <= in_gain;
									if (in_jz) begin
										pos_q   <= '0;
										state_q <= ST_READ;
									end else if (in_jr) begin
										lfsr_q  <= lfsr_n;
										div_q   <= lfsr_n;
										rem_q   <= '0;
										cnt_q   <= '0;
										state_q <= ST_MOD;
									end else begin
										pos_q   <= p3_c;
										state_q <= ST_READ;
									end
								end
							end
							nss_pkg::REQ_TICK: begin
								time_q  <= time_q + 32'd1;
								state_q <= ST_TICK;
							end
							default: ;
						endcase
					end
				end
				ST_MOD: begin
					rem_q <= rem_n;
					div_q <= {div_q[nss_pkg::LFSR_W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						pos_q   <= CW'(rem_n);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					ev_idx_q <= 1'b0;
					if (silent_s1) begin
						snd_vld_q <= 1'b0;
						ev_q[0]   <= '{pitch: snd_pitch_q, vel: 7'd0};
						ev_last_q <= 1'b0;
						state_q   <= off_v ? ST_EMIT : ST_IDLE;
					end else begin
						if (retrig) begin
							ev_q[0]   <= '{pitch: pitch_s1, vel: 7'd0};
							ev_q[1]   <= '{pitch: pitch_s1, vel: ov_s1};
							ev_last_q <= 1'b1;
						end else begin
							ev_q[0]   <= '{pitch: pitch_s1, vel: ov_s1};
							ev_q[1]   <= '{pitch: snd_pitch_q, vel: 7'd0};
							ev_last_q <= off_v;
						end
						snd_pitch_q <= pitch_s1;
						snd_vld_q   <= 1'b1;
						snd_gate_q  <= g_s1;
						gate_end_q  <= time_q + 32'(prod_s1[24:8]);
						off_sent_q  <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_TICK: begin
					if (tick_fire) begin
						ev_q[0]    <= '{pitch: snd_pitch_q, vel: 7'd0};
						ev_idx_q   <= 1'b0;
						ev_last_q  <= 1'b0;
						off_sent_q <= 1'b1;
						state_q    <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (ld_out) begin
						if (ev_idx_q == ev_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							ev_idx_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {1'b0, m_data_q.vel, m_data_q.pitch};
	assign m_tlast  = m_last_q;

	`include "assert_macros.svh"

	// a memory read always targets a step inside the active sequence length
	`NSS_ASSERT_IMP(a_rd_pos, state_q == ST_READ, !pos_q[CW-1] && pos_q < len_c)
	// a gate ending on a tick marks the note as released
	`NSS_ASSERT_NXT(a_tick_off, state_q == ST_TICK && tick_fire, off_sent_q)
	// the event index never runs past the last queued event
	`NSS_ASSERT_IMP(a_emit_idx, state_q == ST_EMIT, !(ev_idx_q && !ev_last_q))

endmodule

`default_nettype wire

FILE: bench/note_step_sequencer_test.sv
`timescale 1ns / 1ps

module note_step_sequencer_test;

	localparam int STEPS = nss_pkg::MAX_STEPS_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 48;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0] req;
		logic       back;
		logic       jz;
		logic       jr;
		logic [7:0] gain;
		logic [3:0] idx;
		logic [4:0] tone;
		logic [6:0] vel;
		logic [8:0] gate;
	} step_req_t;

	typedef struct {
		logic [7:0] pitch;
		logic [6:0] vel;
		logic       last;
	} note_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [nss_pkg::CFG_AW-1:0] cfg_addr = '0;
	logic [nss_pkg::CFG_DW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [nss_pkg::IN_DW-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [nss_pkg::OUT_DW-1:0] m_tdata;
	logic m_tlast;

	note_step_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #1 clk = ~clk;

	step_req_t pending_requests[$];
	note_exp_t due_notes[$];
	int errors = 0;
	int items_accepted = 0;
	int notes_checked = 0;
	int settings_used = 0;
	int hold_token = 0;

	// sequencer copy
	logic [4:0]  cfg_len = nss_pkg::SEQ_LENGTH_RST;
	logic [3:0]  cfg_loop = nss_pkg::LOOP_POINT_RST;
	logic [2:0]  cfg_oct = nss_pkg::OCTAVE_RST;
	logic [4:0]  cfg_npo = nss_pkg::NOTES_OCT_RST;
	logic [4:0]  cfg_shift = nss_pkg::ROW_SHIFT_RST;
	logic        cfg_en = nss_pkg::ENABLED_RST;
	logic [15:0] cfg_ticks = nss_pkg::STEP_TICKS_RST;
	logic [4:0]  tone_mem [STEPS];
	logic [6:0]  vel_mem [STEPS];
	logic [8:0]  gate_mem [STEPS];
	int          play_pos = -1;
	int          snd_pitch = -1;
	logic        off_done = 1'b0;
	int          snd_gate = 256;
	logic [31:0] gate_end = '0;
	logic [31:0] now_ticks = '0;
	logic [15:0] lfsr_q = nss_pkg::LFSR_SEED;

	initial begin
		for (int i = 0; i < STEPS; i++) begin
			tone_mem[i] = 5'd0;
			vel_mem[i] = 7'd127;
			gate_mem[i] = 9'd256;
		end
	end

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t ns: %s mismatch, got %0d, want %0d", $time, field, got, want);
		errors++;
	endtask

	task automatic push_note(input int pitch, input int vel);
		due_notes.push_back('{pitch: 8'(pitch), vel: 7'(vel), last: 1'b0});
	endtask

	task automatic compute_notes(input step_req_t it);
		int first, len, lp, off_pitch, pitch, ov, g, v;
		logic [31:0] diff;
		first = due_notes.size();
		case (it.req)
			nss_pkg::REQ_WRITE: begin
				if (int'(it.idx) < STEPS) begin
					tone_mem[it.idx] = it.tone;
					vel_mem[it.idx] = it.vel;
					gate_mem[it.idx] = it.gate;
				end
			end
			nss_pkg::REQ_TICK: begin
				now_ticks = now_ticks + 32'd1;
				diff = now_ticks - gate_end;
				if (snd_gate < 256 && !off_done && snd_pitch >= 0 && diff != 0 && !diff[31]) begin
					push_note(snd_pitch, 0);
					off_done = 1'b1;
				end
			end
			nss_pkg::REQ_PULSE: begin
				if (cfg_en) begin
					len = int'(cfg_len);
					if (len < 1) len = 1;
					if (len > STEPS) len = STEPS;
					lp = int'(cfg_loop);
					if (lp > len - 1) lp = len - 1;
					play_pos += it.back ? -1 : 1;
					if (!it.back && play_pos >= len) play_pos -= len - lp;
					if (it.back && play_pos < lp) play_pos += len - lp;
					if (play_pos < 0 || play_pos >= len) play_pos = it.back ? len - 1 : lp;
					if (it.jz) begin
						play_pos = 0;
					end else if (it.jr) begin
						lfsr_q = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
						play_pos = int'(lfsr_q) % len;
					end
					off_pitch = (snd_pitch >= 0 && !off_done) ? snd_pitch : -1;
					v = int'(vel_mem[play_pos]);
					if (v <= 1) begin
						snd_pitch = -1;
					end else begin
						pitch = int'(tone_mem[play_pos]) + int'(cfg_shift) + int'(cfg_oct) * int'(cfg_npo);
						ov = (v * int'(it.gain)) >> 7;
						g = int'(gate_mem[play_pos]);
						if (pitch > 255) pitch = 255;
						if (ov > 127) ov = 127;
						if (g == 0) g = 1;
						if (g > 256) g = 256;
						// same-pitch retrigger sends its off first
						if (snd_pitch == pitch && !off_done) begin
							push_note(pitch, 0);
							off_pitch = -1;
						end
						push_note(pitch, ov);
						snd_pitch = pitch;
						snd_gate = g;
						gate_end = now_ticks + ((32'(cfg_ticks) * 32'(g)) >> 8);
						off_done = 1'b0;
					end
					if (off_pitch != -1) begin
						push_note(off_pitch, 0);
						if (off_pitch == snd_pitch) snd_pitch = -1;
					end
				end
			end
			default: ;
		endcase
		if (due_notes.size() > first) due_notes[due_notes.size() - 1].last = 1'b1;
	endtask

	// sender: bursts of transfers with random gaps
	step_req_t cur_req;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				compute_notes(cur_req);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					s_tdata <= {4'd0, cur_req.gate, cur_req.vel, cur_req.tone, cur_req.idx,
						cur_req.gain, cur_req.jr, cur_req.jz, cur_req.back};
					s_tuser <= cur_req.req;
					s_tvalid <= 1'b1;
					if (burst_left == 0) burst_left = $urandom_range(1, 16);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes with rx_cycle bits 8:7, long hold on request
	logic [15:0] rx_cycle = '0;
	int hold_left = 0;
	int hold_seen = 0;
	logic rx_ready;
	note_exp_t head;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle = '0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_notes.size() == 0) begin
					report_mismatch("unexpected event, tdata", int'(m_tdata), 0);
				end else begin
					head = due_notes.pop_front();
					notes_checked++;
					if (m_tdata[7:0] !== head.pitch)
						report_mismatch("note_pitch", int'(m_tdata[7:0]), int'(head.pitch));
					if (m_tdata[14:8] !== head.vel)
						report_mismatch("note_velocity", int'(m_tdata[14:8]), int'(head.vel));
					if (m_tlast !== head.last)
						report_mismatch("last", int'(m_tlast), int'(head.last));
				end
			end
			rx_cycle++;
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_ready = 1'b0;
			end else begin
				case (rx_cycle[8:7])
					2'd0: rx_ready = 1'b1;
					2'd1: rx_ready = 1'($urandom_range(0, 1));
					2'd2: rx_ready = (rx_cycle[2:0] != 3'd0);
					default: rx_ready = ($urandom_range(0, 3) == 0);
				endcase
			end
			m_tready <= rx_ready;
		end
	end

	function automatic step_req_t mk_req(input logic [1:0] req, input logic back, input logic jz,
			input logic jr, input int gain, input int idx, input int tone, input int vel,
			input int gate);
		step_req_t r;
		r.req = req;
		r.back = back;
		r.jz = jz;
		r.jr = jr;
		r.gain = 8'(gain);
		r.idx = 4'(idx);
		r.tone = 5'(tone);
		r.vel = 7'(vel);
		r.gate = 9'(gate);
		return r;
	endfunction

	function automatic step_req_t rand_req(input logic [1:0] req);
		step_req_t r;
		r = mk_req(req, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) == 0),
			($urandom_range(0, 3) == 0),
			($urandom_range(0, 3) == 0) ? 128 : $urandom_range(0, 255),
			$urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 127),
			$urandom_range(0, 511));
		return r;
	endfunction

	task automatic fill_random(input int count);
		int made, r, burst;
		made = 0;
		while (made < count) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				pending_requests.push_back(rand_req(nss_pkg::REQ_WRITE));
				made++;
			end else if (r < 57) begin
				pending_requests.push_back(rand_req(nss_pkg::REQ_PULSE));
				made++;
			end else if (r < 59) begin
				pending_requests.push_back(rand_req(REQ_UNUSED));
			end else begin
				burst = $urandom_range(1, 6);
				for (int k = 0; k < burst; k++)
					pending_requests.push_back(rand_req(nss_pkg::REQ_TICK));
				made += burst;
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || due_notes.size() != 0);
		// a tick or write may still be in flight with nothing to show for it
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int len, input int lp, input int oct, input int npo,
			input int shift, input int en, input int ticks);
		int vals[7];
		vals = '{len, lp, oct, npo, shift, en, ticks};
		for (int i = 0; i < 7; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= nss_pkg::cfg_reg_t'(i);
			cfg_wdata <= 16'(vals[i]);
			case (nss_pkg::cfg_reg_t'(i))
				nss_pkg::REG_SEQ_LENGTH: cfg_len = 5'(vals[i]);
				nss_pkg::REG_LOOP_POINT: cfg_loop = 4'(vals[i]);
				nss_pkg::REG_OCTAVE:     cfg_oct = 3'(vals[i]);
				nss_pkg::REG_NOTES_OCT:  cfg_npo = 5'(vals[i]);
				nss_pkg::REG_ROW_SHIFT:  cfg_shift = 5'(vals[i]);
				nss_pkg::REG_ENABLED:    cfg_en = 1'(vals[i]);
				nss_pkg::REG_STEP_TICKS: cfg_ticks = 16'(vals[i]);
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		// directed part at reset settings
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 128, 9, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 128, 0, 31, 127, 511));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 1, 1, 1, 255, 2, 23, 127, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 0, 0, 0, 0, 3, 31, 1, 511));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 0, 0, 0, 0, 4, 5, 0, 128));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 0, 0, 0, 0, 5, 10, 100, 257));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 0, 0, 0, 0, 15, 0, 127, 256));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 255, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_TICK, 1, 1, 1, 255, 15, 31, 127, 511));
		pending_requests.push_back(mk_req(nss_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 1, 0, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 1, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 0, 1, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 1, 1, 1, 200, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 1, 0, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 1, 0, 0, 128, 0, 0, 0, 0));
		pending_requests.push_back(mk_req(REQ_UNUSED, 1, 1, 1, 255, 15, 31, 127, 511));
		pending_requests.push_back(mk_req(nss_pkg::REQ_WRITE, 0, 0, 0, 0, 0, 31, 127, 1));
		pending_requests.push_back(mk_req(nss_pkg::REQ_PULSE, 0, 1, 0, 64, 0, 0, 0, 0));
		for (int i = 0; i < 3; i++)
			pending_requests.push_back(mk_req(nss_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// extreme settings
		set_config(1, 15, 0, 0, 0, 1, 1);
		fill_random(40);
		hold_token++;
		wait_idle();
		set_config(16, 15, 7, 24, 23, 1, 65535);
		fill_random(40);
		wait_idle();
		set_config(31, 0, 7, 31, 31, 1, 0);
		fill_random(40);
		wait_idle();
		set_config(0, 3, 1, 1, 1, 1, 2);
		fill_random(40);
		wait_idle();
		set_config(8, 2, 3, 12, 0, 0, 4);
		fill_random(20);
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
				$urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 31),
				$urandom_range(0, 31), ($urandom_range(0, 7) != 0),
				($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 8));
			fill_random(80);
			if (ph == 2 || ph == 7) hold_token++;
			wait_idle();
		end

		if (due_notes.size() != 0) report_mismatch("events left over", due_notes.size(), 0);
		$display("%0d items accepted under %0d register settings, %0d note events checked",
			items_accepted, settings_used, notes_checked);
		$display("covered step writes, pulses in all move modes, gate ticks, long output stalls");
		if (errors == 0) begin
			$display("** note_step_sequencer: PASSED **");
		end else begin
			$display("** note_step_sequencer: FAILED **");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("timeout with %0d events outstanding", due_notes.size());
		$display("** note_step_sequencer: FAILED **");
		$finish;
	end

endmodule
